// File: rtl/core/sfpu_pkg.sv
// Shared types, constants and the bound derivation for the minifloat converter.
package sfpu_pkg;

    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAN = 2'd1;

    localparam logic OP_PACK   = 1'b0;
    localparam logic OP_UNPACK = 1'b1;

    localparam logic [3:0] EXP_W_MIN = 4'd2;
    localparam logic [3:0] EXP_W_MAX = 4'd8;
    localparam logic [3:0] EXP_W_RST = 4'd5;
    localparam logic [4:0] MAN_W_MIN = 5'd2;
    localparam logic [4:0] MAN_W_MAX = 5'd23;
    localparam logic [4:0] MAN_W_RST = 5'd10;

    localparam logic [7:0]  FLOAT_BIAS = 8'd127;
    localparam logic [30:0] INF_MAG    = 31'h7F80_0000;

    // Widths and bounds that follow from the two registers.
    typedef struct packed {
        logic [3:0]  ew;
        logic [2:0]  eb;
        logic [4:0]  mw;
        logic [4:0]  shr_amt;
        logic [6:0]  eb_mask;
        logic [22:0] mw_mask;
        logic [31:0] sign_mask;
        logic [31:0] max_code;
        logic [31:0] min_code;
        logic [30:0] max_mag;
        logic [30:0] min_mag;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic        sign;
        logic [7:0]  bexp;
        logic [22:0] frac;
        logic        nan;
        logic        nonneg;
        logic        ge_max;
        logic        le_min;
        logic        u_sign;
        logic        u_neg;
        logic [6:0]  u_mag;
        logic [22:0] u_man;
    } s1_t;

    typedef struct packed {
        logic        op;
        logic [31:0] unp_word;
        logic        sign;
        logic        nonneg;
        logic        clamp;
        logic        sel_max;
        logic [7:0]  field;
        logic [22:0] man_shr;
    } s2_t;

    function automatic cfg_t derive(input logic [3:0] ew, input logic [4:0] mw);
        cfg_t        c;
        logic [8:0]  exp_top;
        logic [5:0]  sign_pos;
        c.ew        = ew;
        c.mw        = mw;
        c.eb        = 3'(ew - 4'd1);
        c.shr_amt   = 5'(5'd23 - mw);
        c.eb_mask   = 7'((8'd1 << c.eb) - 8'd1);
        c.mw_mask   = 23'((24'd1 << mw) - 24'd1);
        sign_pos    = 6'(ew) + 6'(mw);
        c.sign_mask = 32'd1 << sign_pos;
        c.max_code  = (32'(c.eb_mask) << mw) | 32'(c.mw_mask);
        exp_top     = (9'd1 << ew) - 9'd2;
        c.min_code  = (32'(exp_top) << mw) | 32'd1;
        c.max_mag   = {8'(8'd126 + (8'd1 << c.eb)), 23'(c.mw_mask << c.shr_amt)};
        c.min_mag   = {8'(8'd129 - (8'd1 << c.eb)), 23'(23'd1 << c.shr_amt)};
        return c;
    endfunction

endpackage

// File: rtl/core/sfpu_cfg.sv
// Width registers with saturation and the registered bounds derived from them.
module sfpu_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfpu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfpu_pkg::CFG_DAT_W-1:0] cfg_data,
    output sfpu_pkg::cfg_t                 cfg
);

    logic [3:0]     ew_reg, ew_next;
    logic [4:0]     mw_reg, mw_next;
    sfpu_pkg::cfg_t cfg_reg;
    logic [3:0]     ew_wr;
    logic [4:0]     mw_wr;

    assign cfg_ready = 1'b1;

    always_comb begin
        ew_wr = cfg_data[3:0];
        mw_wr = cfg_data;
        if (ew_wr < sfpu_pkg::EXP_W_MIN) begin
            ew_wr = sfpu_pkg::EXP_W_MIN;
        end else if (ew_wr > sfpu_pkg::EXP_W_MAX) begin
            ew_wr = sfpu_pkg::EXP_W_MAX;
        end
        if (mw_wr < sfpu_pkg::MAN_W_MIN) begin
            mw_wr = sfpu_pkg::MAN_W_MIN;
        end else if (mw_wr > sfpu_pkg::MAN_W_MAX) begin
            mw_wr = sfpu_pkg::MAN_W_MAX;
        end
        ew_next = ew_reg;
        mw_next = mw_reg;
        if (cfg_valid) begin
            case (cfg_index)
                sfpu_pkg::CFG_IDX_EXP: ew_next = ew_wr;
                sfpu_pkg::CFG_IDX_MAN: mw_next = mw_wr;
                default: ;
            endcase
        end
    end

    // Derive bounds from the next values so they are ready with the registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ew_reg  <= sfpu_pkg::EXP_W_RST;
            mw_reg  <= sfpu_pkg::MAN_W_RST;
            cfg_reg <= sfpu_pkg::derive(sfpu_pkg::EXP_W_RST, sfpu_pkg::MAN_W_RST);
        end else begin
            ew_reg  <= ew_next;
            mw_reg  <= mw_next;
            cfg_reg <= sfpu_pkg::derive(ew_next, mw_next);
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/sfpu_pipe.sv
// Three-stage convert pipeline: classify, convert fields, assemble the word.
module sfpu_pipe (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sfpu_pkg::cfg_t               cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [sfpu_pkg::VALUE_W-1:0] s_value_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sfpu_pkg::VALUE_W-1:0] m_value_out,
    output logic                         m_clamped
);

    logic                         v1_reg, v2_reg, v3_reg;
    logic                         rdy1, rdy2, rdy3;
    sfpu_pkg::s1_t                s1_reg, s1_next;
    sfpu_pkg::s2_t                s2_reg, s2_next;
    logic [sfpu_pkg::VALUE_W-1:0] out_reg, out_next;
    logic                         clamp_reg, clamp_next;

    logic [30:0] mag;
    logic [31:0] sh;
    logic [8:0]  sh_lo;
    logic        negp;
    logic [7:0]  magp;
    logic [7:0]  be;
    logic [31:0] pack_word;
    logic [31:0] clamp_word;

    // A stage takes a beat when it is empty or its successor moves.
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // Stage 1: compare against bounds, pull the small-code fields apart.
    always_comb begin
        mag              = s_value_in[30:0];
        sh               = s_value_in >> cfg.mw;
        sh_lo            = sh[8:0];
        s1_next.op       = s_operation;
        s1_next.sign     = s_value_in[31];
        s1_next.bexp     = s_value_in[30:23];
        s1_next.frac     = s_value_in[22:0];
        s1_next.nan      = mag > sfpu_pkg::INF_MAG;
        s1_next.nonneg   = !s_value_in[31] || (mag == 31'd0);
        s1_next.ge_max   = mag >= cfg.max_mag;
        s1_next.le_min   = mag <= cfg.min_mag;
        s1_next.u_sign   = sh_lo[cfg.ew];
        s1_next.u_neg    = sh_lo[{1'b0, cfg.eb}];
        s1_next.u_mag    = sh_lo[6:0] & cfg.eb_mask;
        s1_next.u_man    = s_value_in[22:0] & cfg.mw_mask;
    end

    // Stage 2: rebias exponents, shift mantissas, decide clamping.
    always_comb begin
        negp             = s1_reg.bexp < sfpu_pkg::FLOAT_BIAS;
        magp             = negp ? (sfpu_pkg::FLOAT_BIAS - s1_reg.bexp)
                                : (s1_reg.bexp - sfpu_pkg::FLOAT_BIAS);
        be               = s1_reg.u_neg ? (sfpu_pkg::FLOAT_BIAS - 8'(s1_reg.u_mag))
                                        : (sfpu_pkg::FLOAT_BIAS + 8'(s1_reg.u_mag));
        s2_next.op       = s1_reg.op;
        s2_next.unp_word = {s1_reg.u_sign, be, 23'(s1_reg.u_man << cfg.shr_amt)};
        s2_next.sign     = s1_reg.sign;
        s2_next.nonneg   = s1_reg.nonneg;
        s2_next.clamp    = !s1_reg.nan && (s1_reg.ge_max || s1_reg.le_min);
        s2_next.sel_max  = s1_reg.ge_max;
        s2_next.field    = (8'(negp) << cfg.eb) | {1'b0, magp[6:0] & cfg.eb_mask};
        s2_next.man_shr  = s1_reg.frac >> cfg.shr_amt;
    end

    // Stage 3: place the fields of the small code and pick the result.
    always_comb begin
        pack_word  = (s2_reg.sign ? cfg.sign_mask : 32'd0)
                   | (32'(s2_reg.field) << cfg.mw)
                   | 32'(s2_reg.man_shr);
        clamp_word = (s2_reg.sel_max ? cfg.max_code : cfg.min_code)
                   | (s2_reg.nonneg ? 32'd0 : cfg.sign_mask);
        if (s2_reg.op == sfpu_pkg::OP_UNPACK) begin
            out_next   = s2_reg.unp_word;
            clamp_next = 1'b0;
        end else begin
            out_next   = s2_reg.clamp ? clamp_word : pack_word;
            clamp_next = s2_reg.clamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_reg <= s1_next;
        end
        if (rdy2) begin
            s2_reg <= s2_next;
        end
        if (rdy3) begin
            out_reg   <= out_next;
            clamp_reg <= clamp_next;
        end
    end

    assign m_valid     = v3_reg;
    assign m_value_out = out_reg;
    assign m_clamped   = clamp_reg;

endmodule

// File: rtl/core/small_float_pack_unpack.sv
// Minifloat converter: IEEE single to and from a small sign-magnitude-exponent float.
// Operation 0 packs an IEEE single into a code of sign, exponent_width exponent bits
// (top bit is the exponent's sign, the rest its magnitude) and mantissa_width truncated
// mantissa bits; values at or beyond the representable range saturate to the largest or
// smallest code with clamped set. Operation 1 unpacks a code in the low bits of value_in
// back to an IEEE single. Widths are written through the cfg channel (index 0 exponent
// width, saturated to 2..8; index 1 mantissa width, saturated to 2..23); the user
// must write them only while no beat is in flight; the block does not enforce it. The
// block accepts one beat every clock unless m_ready stalls it; its three register
// stages (bound compare, field conversion, code assembly), the first loaded on
// acceptance, carry each beat to m_valid; back-pressure holds them without loss.
module small_float_pack_unpack (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfpu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfpu_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [sfpu_pkg::VALUE_W-1:0]   s_value_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sfpu_pkg::VALUE_W-1:0]   m_value_out,
    output logic                           m_clamped
);

    sfpu_pkg::cfg_t cfg;

    sfpu_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfpu_pipe u_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value_in  (s_value_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_clamped   (m_clamped)
    );

endmodule

// File: tb/tb_small_float_pack_unpack.sv
// Self-checking testbench for the minifloat pack/unpack converter.
`timescale 1ns / 1ps

module tb_small_float_pack_unpack;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 78;
    localparam int NUM_PHASES  = 12;
    localparam int DRAIN_WAIT  = 8;
    localparam logic [sfpu_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct {
        logic        op;
        logic [31:0] word_in;
        logic [31:0] word;
        logic        clamp;
    } conv_result_t;

    class conversion_scoreboard;
        logic [3:0]   exp_w_reg;
        logic [4:0]   man_w_reg;
        conv_result_t expected_q[$];
        int           failures;

        function new();
            exp_w_reg = sfpu_pkg::EXP_W_RST;
            man_w_reg = sfpu_pkg::MAN_W_RST;
            failures  = 0;
        endfunction

        function int unsigned exp_w();
            if (exp_w_reg < sfpu_pkg::EXP_W_MIN) return sfpu_pkg::EXP_W_MIN;
            if (exp_w_reg > sfpu_pkg::EXP_W_MAX) return sfpu_pkg::EXP_W_MAX;
            return exp_w_reg;
        endfunction

        function int unsigned man_w();
            if (man_w_reg < sfpu_pkg::MAN_W_MIN) return sfpu_pkg::MAN_W_MIN;
            if (man_w_reg > sfpu_pkg::MAN_W_MAX) return sfpu_pkg::MAN_W_MAX;
            return man_w_reg;
        endfunction

        function void write_reg(logic [sfpu_pkg::CFG_IDX_W-1:0] idx,
                                logic [sfpu_pkg::CFG_DAT_W-1:0] data);
            if (idx == sfpu_pkg::CFG_IDX_EXP) exp_w_reg = data[3:0];
            else if (idx == sfpu_pkg::CFG_IDX_MAN) man_w_reg = data;
        endfunction

        function logic [31:0] unpack_code(logic [31:0] c);
            int unsigned ew, mw, eb;
            logic [31:0] s, mag, neg, be, man;
            ew  = exp_w();
            mw  = man_w();
            eb  = ew - 1;
            s   = (c >> (ew + mw)) & 32'd1;
            mag = (c >> mw) & ((32'd1 << eb) - 32'd1);
            neg = (c >> (eb + mw)) & 32'd1;
            be  = neg[0] ? 32'd127 - mag : 32'd127 + mag;
            man = (c & ((32'd1 << mw) - 32'd1)) << (23 - mw);
            return (s << 31) | (be << 23) | man;
        endfunction

        function logic [31:0] pack_plain(logic [31:0] x);
            int unsigned ew, mw, eb;
            logic [31:0] s, bexp, neg, mag, v;
            ew   = exp_w();
            mw   = man_w();
            eb   = ew - 1;
            s    = (x >> 31) & 32'd1;
            bexp = (x >> 23) & 32'hFF;
            neg  = (bexp < 32'd127) ? 32'd1 : 32'd0;
            mag  = neg[0] ? 32'd127 - bexp : bexp - 32'd127;
            v    = s << (ew + mw);
            v    = v | (((neg << eb) | (mag & ((32'd1 << eb) - 32'd1))) << mw);
            v    = v | ((x & 32'h007F_FFFF) >> (23 - mw));
            return v;
        endfunction

        function logic [31:0] max_code();
            return (((32'd1 << (exp_w() - 1)) - 32'd1) << man_w())
                   | ((32'd1 << man_w()) - 32'd1);
        endfunction

        function logic [31:0] min_code();
            return (((32'd1 << exp_w()) - 32'd2) << man_w()) | 32'd1;
        endfunction

        function logic [31:0] max_mag();
            return unpack_code(max_code()) & 32'h7FFF_FFFF;
        endfunction

        function logic [31:0] min_mag();
            return unpack_code(min_code()) & 32'h7FFF_FFFF;
        endfunction

        function logic [31:0] code_sign();
            return 32'd1 << (exp_w() + man_w());
        endfunction

        function void note_beat(logic op, logic [31:0] x);
            conv_result_t r;
            logic [31:0]  mag, sbit;
            bit           is_nan;
            r.op      = op;
            r.word_in = x;
            r.clamp   = 1'b0;
            if (op == sfpu_pkg::OP_UNPACK) begin
                r.word = unpack_code(x);
            end else begin
                mag    = x & 32'h7FFF_FFFF;
                is_nan = mag > {1'b0, sfpu_pkg::INF_MAG};
                // negative zero counts as non-negative
                sbit   = (!x[31] || mag == 32'd0) ? 32'd0 : code_sign();
                if (!is_nan && mag >= max_mag()) begin
                    r.word  = max_code() | sbit;
                    r.clamp = 1'b1;
                end else if (!is_nan && mag <= min_mag()) begin
                    r.word  = min_code() | sbit;
                    r.clamp = 1'b1;
                end else begin
                    r.word = pack_plain(x);
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_beat(logic [31:0] word, logic clamp);
            conv_result_t r;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: value %h clamped %b", word, clamp);
                return;
            end
            r = expected_q.pop_front();
            if (word !== r.word || clamp !== r.clamp) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch op %0d in %h: expected %h/%b got %h/%b",
                             r.op, r.word_in, r.word, r.clamp, word, clamp);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_valid   = 1'b0;
    logic                           cfg_ready;
    logic [sfpu_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [sfpu_pkg::CFG_DAT_W-1:0] cfg_data    = '0;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    logic                           s_operation = sfpu_pkg::OP_PACK;
    logic [sfpu_pkg::VALUE_W-1:0]   s_value_in  = '0;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    logic [sfpu_pkg::VALUE_W-1:0]   m_value_out;
    logic                           m_clamped;

    conversion_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    small_float_pack_unpack u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operation(s_operation),
        .s_value_in (s_value_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value_out(m_value_out),
        .m_clamped  (m_clamped)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("small_float_pack_unpack verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Observe every handshake on the pre-edge values.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_beat(s_operation, s_value_in);
            if (m_valid && m_ready) sb.check_beat(m_value_out, m_clamped);
        end
    end

    task automatic send_item(logic op, logic [31:0] val);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value_in  <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drain();
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic cfg_beat(logic [sfpu_pkg::CFG_IDX_W-1:0] idx,
                            logic [sfpu_pkg::CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_widths(logic [sfpu_pkg::CFG_DAT_W-1:0] ew,
                              logic [sfpu_pkg::CFG_DAT_W-1:0] mw, bit poke_unused);
        s_valid <= 1'b0;
        wait_drain();
        cfg_beat(sfpu_pkg::CFG_IDX_EXP, ew);
        cfg_beat(sfpu_pkg::CFG_IDX_MAN, mw);
        if (poke_unused)
            cfg_beat(CFG_IDX_UNUSED, sfpu_pkg::CFG_DAT_W'($urandom_range(31)));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_float();
        logic [31:0] sgn, hi, lo, lim, bexp;
        int unsigned pick;
        sgn  = $urandom_range(1) ? 32'h8000_0000 : 32'd0;
        hi   = sb.max_mag();
        lo   = sb.min_mag();
        lim  = (32'd1 << (sb.exp_w() - 1)) - 32'd1;
        pick = $urandom_range(9);
        case (pick)
            0, 1: return $urandom;
            2, 3: return sgn | (hi + $urandom_range(8) - 32'd4);
            4, 5, 6: begin
                // exponent inside the representable range, random mantissa
                bexp = 32'd127 - lim + $urandom_range(2 * lim);
                return sgn | (bexp << 23) | ($urandom & 32'h007F_FFFF);
            end
            7: return sgn | (lo + $urandom_range(8) - 32'd4);
            8: begin
                case ($urandom_range(2))
                    0: return sgn;
                    1: return sgn | {1'b0, sfpu_pkg::INF_MAG};
                    default: return sgn | {1'b0, sfpu_pkg::INF_MAG}
                                    | (($urandom & 32'h007F_FFFF) | 32'd1);
                endcase
            end
            default: return sgn | (hi - ($urandom & 32'h0000_FFFF));
        endcase
    endfunction

    function automatic logic [31:0] random_code();
        int unsigned width;
        logic [31:0] raw;
        width = sb.exp_w() + sb.man_w() + 1;
        raw   = $urandom;
        if ($urandom_range(3) != 0 && width < 32) raw = raw & ((32'd1 << width) - 32'd1);
        return raw;
    endfunction

    task automatic run_directed();
        logic [31:0] hi, lo, sgn;
        hi  = sb.max_mag();
        lo  = sb.min_mag();
        sgn = 32'h8000_0000;
        send_item(sfpu_pkg::OP_PACK, 32'h0000_0000);
        send_item(sfpu_pkg::OP_PACK, 32'h8000_0000);
        send_item(sfpu_pkg::OP_PACK, 32'h7F80_0000);
        send_item(sfpu_pkg::OP_PACK, 32'hFF80_0000);
        send_item(sfpu_pkg::OP_PACK, 32'h7FC0_0000);
        send_item(sfpu_pkg::OP_PACK, 32'h7F80_0001);
        send_item(sfpu_pkg::OP_PACK, 32'hFFFF_FFFF);
        send_item(sfpu_pkg::OP_PACK, 32'h7FFF_FFFF);
        send_item(sfpu_pkg::OP_PACK, 32'h3F80_0000);
        send_item(sfpu_pkg::OP_PACK, 32'hBF80_0000);
        send_item(sfpu_pkg::OP_PACK, hi);
        send_item(sfpu_pkg::OP_PACK, hi - 32'd1);
        send_item(sfpu_pkg::OP_PACK, sgn | hi);
        send_item(sfpu_pkg::OP_PACK, lo);
        send_item(sfpu_pkg::OP_PACK, lo + 32'd1);
        send_item(sfpu_pkg::OP_PACK, sgn | (lo + 32'd1));
        send_item(sfpu_pkg::OP_PACK, 32'h0000_0001);
        send_item(sfpu_pkg::OP_PACK, 32'h0080_0000);
        send_item(sfpu_pkg::OP_UNPACK, 32'h0000_0000);
        send_item(sfpu_pkg::OP_UNPACK, 32'hFFFF_FFFF);
        send_item(sfpu_pkg::OP_UNPACK, sb.max_code());
        send_item(sfpu_pkg::OP_UNPACK, sb.min_code());
        send_item(sfpu_pkg::OP_UNPACK, sb.min_code() | sb.code_sign());
        send_item(sfpu_pkg::OP_UNPACK, $urandom);
    endtask

    initial begin
        logic [sfpu_pkg::CFG_DAT_W-1:0] ew_tab[NUM_PHASES];
        logic [sfpu_pkg::CFG_DAT_W-1:0] mw_tab[NUM_PHASES];
        ew_tab = '{5'd2, 5'd8, 5'd2, 5'd8, 5'd0, 5'd15, 5'd26, 5'd1, 5'd0, 5'd3, 5'd6, 5'd9};
        mw_tab = '{5'd2, 5'd23, 5'd23, 5'd2, 5'd1, 5'd31, 5'd24, 5'd0, 5'd0, 5'd7, 5'd16, 5'd12};
        ew_tab[8] = sfpu_pkg::CFG_DAT_W'($urandom_range(31));
        mw_tab[8] = sfpu_pkg::CFG_DAT_W'($urandom_range(31));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct  = 15;
        recv_stall_pct = 58;
        run_directed();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_widths(ew_tab[p], mw_tab[p], p == 5);
            if (p == NUM_PHASES / 3) begin
                send_idle_pct  = 58;
                recv_stall_pct = 15;
            end else if (p == 2 * NUM_PHASES / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(99) < 55) send_item(sfpu_pkg::OP_PACK, random_float());
                else send_item(sfpu_pkg::OP_UNPACK, random_code());
            end
        end

        s_valid <= 1'b0;
        wait_drain();
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("small_float_pack_unpack verification clean");
        end else begin
            $display("small_float_pack_unpack verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/sfpu_pkg.sv
rtl/core/sfpu_cfg.sv
rtl/core/sfpu_pipe.sv
rtl/core/small_float_pack_unpack.sv
tb/tb_small_float_pack_unpack.sv
